@@ hw/rtl/mifb_pkg.sv @@
// Package for the multichannel IIR filter bank sum core.
// Holds payload types, fixed-point constants, controller states and
// the command/status structs shared by the controller and the datapath.
`default_nettype none

package mifb_pkg;

  // Field widths fixed by the item format
  localparam int CHANNEL_W = 4;
  localparam int TAP_W     = 4;
  localparam int VALUE_W   = 24;
  localparam int EST_W     = 32;
  localparam int SUM_W     = 40;
  localparam int PROD_W    = VALUE_W + EST_W;
  localparam int ACC_W     = 64;

  // Coefficient format Q9.14, result rounded back to 15 fractional bits
  localparam int COEF_FRAC_BITS = 14;

  localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1) << (COEF_FRAC_BITS - 1);
  localparam logic signed [EST_W-1:0] EST_MAX = {1'b0, {(EST_W-1){1'b1}}};
  localparam logic signed [EST_W-1:0] EST_MIN = {1'b1, {(EST_W-1){1'b0}}};
  localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

  typedef enum logic [1:0] {
    ACT_SAMPLE = 2'd0,
    ACT_LOAD_B = 2'd1,
    ACT_LOAD_F = 2'd2,
    ACT_CLEAR  = 2'd3
  } action_e;

  typedef struct packed {
    action_e                     action;
    logic [CHANNEL_W-1:0]        channel;
    logic [TAP_W-1:0]            tap;
    logic signed [VALUE_W-1:0]   value;
    logic                        step_last;
  } in_item_t;

  typedef struct packed {
    logic signed [EST_W-1:0] estimate;
    logic                    saturated;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_CLR_ALL,
    ST_IDLE,
    ST_DECODE,
    ST_CLR_HIST,
    ST_PUSH,
    ST_MAC_B,
    ST_MAC_F,
    ST_DRAIN,
    ST_ROUND,
    ST_ACCUM,
    ST_EMIT
  } ctrl_state_e;

  typedef struct packed {
    logic capture;     // latch the accepted transaction
    logic load_b;      // write numerator coefficient
    logic load_f;      // write denominator coefficient
    logic clr_sum;     // zero running sum and clip flag
    logic sweep;       // clearing sweep, one entry per cycle
    logic sweep_coef;  // sweep also zeros the coefficient memories
    logic push;        // store new sample, set up ring pointers
    logic issue_b;     // issue one numerator tap
    logic issue_f;     // issue one feedback tap
    logic round;       // round and saturate the channel output
    logic accum;       // store channel output, add into running sum
    logic emit;        // load the output register
  } dp_cmd_t;

  typedef struct packed {
    action_e action;
    logic    ch_ok;
    logic    tap_ok_b;
    logic    tap_ok_f;
    logic    step_last;
    logic    sweep_done;
    logic    tap_last_b;
    logic    tap_last_f;
    logic    pipe_idle;
    logic    out_free;
  } dp_sts_t;

endpackage

`default_nettype wire

@@ hw/rtl/mifb_stream_if.sv @@
// Valid/ready stream interface used for the item and result channels.
// Payload type is set per instance; no dependencies.
`default_nettype none

interface mifb_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/mifb_ram.sv @@
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`default_nettype none

module mifb_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

@@ hw/rtl/mifb_ctrl.sv @@
// Controller state machine of the filter bank core.
// Depends on mifb_pkg (states, command and status structs).
`default_nettype none

module mifb_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire mifb_pkg::dp_sts_t sts_i,
  output mifb_pkg::dp_cmd_t      cmd_o
);

  mifb_pkg::ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mifb_pkg::ST_CLR_ALL;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      mifb_pkg::ST_CLR_ALL: begin
        if (sts_i.sweep_done) state_d = mifb_pkg::ST_IDLE;
      end
      mifb_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = mifb_pkg::ST_DECODE;
      end
      mifb_pkg::ST_DECODE: begin
        case (sts_i.action)
          mifb_pkg::ACT_CLEAR:  state_d = mifb_pkg::ST_CLR_HIST;
          mifb_pkg::ACT_SAMPLE: state_d = sts_i.ch_ok ? mifb_pkg::ST_PUSH : mifb_pkg::ST_IDLE;
          default:              state_d = mifb_pkg::ST_IDLE;
        endcase
      end
      mifb_pkg::ST_CLR_HIST: begin
        if (sts_i.sweep_done) state_d = mifb_pkg::ST_IDLE;
      end
      mifb_pkg::ST_PUSH:  state_d = mifb_pkg::ST_MAC_B;
      mifb_pkg::ST_MAC_B: begin
        if (sts_i.tap_last_b) state_d = mifb_pkg::ST_MAC_F;
      end
      mifb_pkg::ST_MAC_F: begin
        if (sts_i.tap_last_f) state_d = mifb_pkg::ST_DRAIN;
      end
      mifb_pkg::ST_DRAIN: begin
        if (sts_i.pipe_idle) state_d = mifb_pkg::ST_ROUND;
      end
      mifb_pkg::ST_ROUND: state_d = mifb_pkg::ST_ACCUM;
      mifb_pkg::ST_ACCUM: begin
        state_d = sts_i.step_last ? mifb_pkg::ST_EMIT : mifb_pkg::ST_IDLE;
      end
      mifb_pkg::ST_EMIT: begin
        if (sts_i.out_free) state_d = mifb_pkg::ST_IDLE;
      end
      default: state_d = mifb_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      mifb_pkg::ST_CLR_ALL: begin
        cmd_o.sweep      = 1'b1;
        cmd_o.sweep_coef = 1'b1;
      end
      mifb_pkg::ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      mifb_pkg::ST_DECODE: begin
        cmd_o.load_b  = (sts_i.action == mifb_pkg::ACT_LOAD_B) && sts_i.ch_ok && sts_i.tap_ok_b;
        cmd_o.load_f  = (sts_i.action == mifb_pkg::ACT_LOAD_F) && sts_i.ch_ok && sts_i.tap_ok_f;
        cmd_o.clr_sum = (sts_i.action == mifb_pkg::ACT_CLEAR);
      end
      mifb_pkg::ST_CLR_HIST: cmd_o.sweep   = 1'b1;
      mifb_pkg::ST_PUSH:     cmd_o.push    = 1'b1;
      mifb_pkg::ST_MAC_B:    cmd_o.issue_b = 1'b1;
      mifb_pkg::ST_MAC_F:    cmd_o.issue_f = 1'b1;
      mifb_pkg::ST_DRAIN:    ;
      mifb_pkg::ST_ROUND:    cmd_o.round   = 1'b1;
      mifb_pkg::ST_ACCUM:    cmd_o.accum   = 1'b1;
      mifb_pkg::ST_EMIT:     cmd_o.emit    = sts_i.out_free;
      default:               ;
    endcase
  end

endmodule

`default_nettype wire

@@ hw/rtl/mifb_dp.sv @@
// Datapath of the filter bank core: coefficient and history memories,
// ring pointers, shared multiply-accumulate, rounding and the running sum.
// Depends on mifb_pkg and mifb_ram.
`default_nettype none

module mifb_dp #(
  parameter int NUM_CHANNELS = 16,
  parameter int NUM_B_TAPS   = 16,
  parameter int NUM_F_TAPS   = 8
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire mifb_pkg::dp_cmd_t   cmd_i,
  output mifb_pkg::dp_sts_t        sts_o,
  input  wire mifb_pkg::in_item_t  item_i,
  input  wire logic                out_ready_i,
  output logic                     out_valid_o,
  output mifb_pkg::out_item_t      out_item_o
);

  localparam int VW = mifb_pkg::VALUE_W;
  localparam int EW = mifb_pkg::EST_W;
  localparam int SW = mifb_pkg::SUM_W;
  localparam int AW = mifb_pkg::ACC_W;
  localparam int PW = mifb_pkg::PROD_W;

  localparam int FB_TAPS   = NUM_F_TAPS - 1;
  localparam int B_DEPTH   = NUM_CHANNELS * NUM_B_TAPS;
  localparam int F_DEPTH   = NUM_CHANNELS * NUM_F_TAPS;
  localparam int W_DEPTH   = NUM_CHANNELS * FB_TAPS;
  localparam int BA_W      = (B_DEPTH > 1) ? $clog2(B_DEPTH) : 1;
  localparam int FA_W      = (F_DEPTH > 1) ? $clog2(F_DEPTH) : 1;
  localparam int WA_W      = (W_DEPTH > 1) ? $clog2(W_DEPTH) : 1;
  localparam int CH_W      = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int HB_W      = (NUM_B_TAPS > 1) ? $clog2(NUM_B_TAPS) : 1;
  localparam int HW_W      = (FB_TAPS > 1) ? $clog2(FB_TAPS) : 1;
  localparam int TAP_MAX   = (NUM_B_TAPS > NUM_F_TAPS) ? NUM_B_TAPS : NUM_F_TAPS;
  localparam int TC_W      = $clog2(TAP_MAX);
  localparam int SWEEP_LEN = (B_DEPTH > F_DEPTH) ? B_DEPTH : F_DEPTH;
  localparam int SWP_W     = $clog2(SWEEP_LEN + 1);

  // Captured transaction
  mifb_pkg::in_item_t item_q;

  // Per-channel ring heads: position of the newest sample / output
  logic [HB_W-1:0] hb_q [NUM_CHANNELS];
  logic [HW_W-1:0] hw_q [NUM_CHANNELS];

  logic [HB_W-1:0]  upos_q;
  logic [HW_W-1:0]  wpos_q;
  logic [TC_W-1:0]  tap_q;
  logic [SWP_W-1:0] sweep_q;

  logic v1_q, fb1_q, v2_q, fb2_q;
  logic signed [PW-1:0] prod_q;
  logic signed [AW-1:0] acc_q;
  logic signed [EW-1:0] wi_q;
  logic                 wclip_q;
  logic signed [SW-1:0] sum_q;
  logic                 clip_q;
  logic                 out_valid_q;
  mifb_pkg::out_item_t  out_q;

  logic [CH_W-1:0] ch_idx;
  logic [BA_W-1:0] b_base;
  logic [FA_W-1:0] f_base;
  logic [WA_W-1:0] w_base;
  logic [HB_W-1:0] hb_cur, hb_inc, upos_dec;
  logic [HW_W-1:0] hw_cur, hw_inc, wpos_dec;

  assign ch_idx = CH_W'(item_q.channel);
  assign b_base = BA_W'(int'(ch_idx) * NUM_B_TAPS);
  assign f_base = FA_W'(int'(ch_idx) * NUM_F_TAPS);
  assign w_base = WA_W'(int'(ch_idx) * FB_TAPS);

  assign hb_cur   = hb_q[ch_idx];
  assign hw_cur   = hw_q[ch_idx];
  assign hb_inc   = (hb_cur == HB_W'(NUM_B_TAPS - 1)) ? '0 : hb_cur + HB_W'(1);
  assign hw_inc   = (hw_cur == HW_W'(FB_TAPS - 1)) ? '0 : hw_cur + HW_W'(1);
  // walking back in time through the rings
  assign upos_dec = (upos_q == '0) ? HB_W'(NUM_B_TAPS - 1) : upos_q - HB_W'(1);
  assign wpos_dec = (wpos_q == '0) ? HW_W'(FB_TAPS - 1) : wpos_q - HW_W'(1);

  // ---- memories ----
  logic            sweep_b, sweep_f, sweep_w;
  logic            u_we, b_we, f_we, w_we;
  logic [BA_W-1:0] u_waddr, b_waddr, u_raddr, b_raddr;
  logic [FA_W-1:0] f_waddr, f_raddr;
  logic [WA_W-1:0] w_waddr, w_raddr;
  logic [VW-1:0]   u_wdata, b_wdata, f_wdata, u_rdata, b_rdata, f_rdata;
  logic [EW-1:0]   w_wdata, w_rdata;

  assign sweep_b = cmd_i.sweep && (int'(sweep_q) < B_DEPTH);
  assign sweep_f = cmd_i.sweep && (int'(sweep_q) < F_DEPTH);
  assign sweep_w = cmd_i.sweep && (int'(sweep_q) < W_DEPTH);

  assign u_we    = cmd_i.push || sweep_b;
  assign u_waddr = cmd_i.sweep ? BA_W'(sweep_q) : b_base + BA_W'(hb_inc);
  assign u_wdata = cmd_i.sweep ? '0 : item_q.value;
  assign u_raddr = b_base + BA_W'(upos_q);

  assign b_we    = cmd_i.load_b || (sweep_b && cmd_i.sweep_coef);
  assign b_waddr = cmd_i.sweep ? BA_W'(sweep_q) : b_base + BA_W'(item_q.tap);
  assign b_wdata = cmd_i.sweep ? '0 : item_q.value;
  assign b_raddr = b_base + BA_W'(tap_q);

  assign f_we    = cmd_i.load_f || (sweep_f && cmd_i.sweep_coef);
  assign f_waddr = cmd_i.sweep ? FA_W'(sweep_q) : f_base + FA_W'(item_q.tap);
  assign f_wdata = cmd_i.sweep ? '0 : item_q.value;
  assign f_raddr = f_base + FA_W'(tap_q);

  assign w_we    = cmd_i.accum || sweep_w;
  assign w_waddr = cmd_i.sweep ? WA_W'(sweep_q) : w_base + WA_W'(hw_inc);
  assign w_wdata = cmd_i.sweep ? '0 : wi_q;
  assign w_raddr = w_base + WA_W'(wpos_q);

  mifb_ram #(.WIDTH(VW), .DEPTH(B_DEPTH)) u_hist_ram (
    .clk_i, .we_i(u_we), .waddr_i(u_waddr), .wdata_i(u_wdata),
    .raddr_i(u_raddr), .rdata_o(u_rdata)
  );

  mifb_ram #(.WIDTH(VW), .DEPTH(B_DEPTH)) u_bcoef_ram (
    .clk_i, .we_i(b_we), .waddr_i(b_waddr), .wdata_i(b_wdata),
    .raddr_i(b_raddr), .rdata_o(b_rdata)
  );

  mifb_ram #(.WIDTH(VW), .DEPTH(F_DEPTH)) u_fcoef_ram (
    .clk_i, .we_i(f_we), .waddr_i(f_waddr), .wdata_i(f_wdata),
    .raddr_i(f_raddr), .rdata_o(f_rdata)
  );

  mifb_ram #(.WIDTH(EW), .DEPTH(W_DEPTH)) u_whist_ram (
    .clk_i, .we_i(w_we), .waddr_i(w_waddr), .wdata_i(w_wdata),
    .raddr_i(w_raddr), .rdata_o(w_rdata)
  );

  // ---- shared multiplier, one product per cycle ----
  logic signed [VW-1:0] mul_a;
  logic signed [EW-1:0] mul_b;

  assign mul_a = fb1_q ? $signed(f_rdata) : $signed(b_rdata);
  assign mul_b = fb1_q ? $signed(w_rdata) : EW'($signed(u_rdata));

  // ---- round half up, saturate to 32 bits ----
  logic signed [AW-1:0] rnd_sh;
  logic                 rnd_ovf;
  logic signed [EW-1:0] wi_d;

  assign rnd_sh  = (acc_q + mifb_pkg::ROUND_HALF) >>> mifb_pkg::COEF_FRAC_BITS;
  assign rnd_ovf = !((&rnd_sh[AW-1:EW-1]) || !(|rnd_sh[AW-1:EW-1]));
  assign wi_d    = rnd_ovf ? (rnd_sh[AW-1] ? mifb_pkg::EST_MIN : mifb_pkg::EST_MAX)
                           : rnd_sh[EW-1:0];

  // ---- running sum, saturating at 40 bits ----
  logic signed [SW:0]   sum_ext;
  logic                 sum_ovf;
  logic signed [SW-1:0] sum_d;

  assign sum_ext = (SW+1)'(sum_q) + (SW+1)'(wi_q);
  assign sum_ovf = sum_ext[SW] != sum_ext[SW-1];
  assign sum_d   = sum_ovf ? (sum_ext[SW] ? mifb_pkg::SUM_MIN : mifb_pkg::SUM_MAX)
                           : sum_ext[SW-1:0];

  // ---- final clamp to the estimate width ----
  logic                 est_ovf;
  logic signed [EW-1:0] est_d;

  assign est_ovf = !((&sum_q[SW-1:EW-1]) || !(|sum_q[SW-1:EW-1]));
  assign est_d   = est_ovf ? (sum_q[SW-1] ? mifb_pkg::EST_MIN : mifb_pkg::EST_MAX)
                           : sum_q[EW-1:0];

  // ---- payload registers ----
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) item_q <= item_i;
    prod_q <= mul_a * mul_b;
    if (cmd_i.round) begin
      wi_q    <= wi_d;
      wclip_q <= rnd_ovf;
    end
    if (cmd_i.emit) begin
      out_q.estimate  <= est_d;
      out_q.saturated <= clip_q || est_ovf;
    end
  end

  // ---- control registers ----
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        hb_q[i] <= '0;
        hw_q[i] <= '0;
      end
      upos_q      <= '0;
      wpos_q      <= '0;
      tap_q       <= '0;
      sweep_q     <= '0;
      v1_q        <= 1'b0;
      fb1_q       <= 1'b0;
      v2_q        <= 1'b0;
      fb2_q       <= 1'b0;
      acc_q       <= '0;
      sum_q       <= '0;
      clip_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      sweep_q <= cmd_i.sweep ? sweep_q + SWP_W'(1) : '0;

      if (cmd_i.push) begin
        hb_q[ch_idx] <= hb_inc;
        upos_q       <= hb_inc;
        wpos_q       <= hw_cur;
        tap_q        <= '0;
      end else if (cmd_i.issue_b) begin
        upos_q <= upos_dec;
        // feedback walk starts at delay one
        tap_q  <= sts_o.tap_last_b ? TC_W'(1) : tap_q + TC_W'(1);
      end else if (cmd_i.issue_f) begin
        wpos_q <= wpos_dec;
        tap_q  <= tap_q + TC_W'(1);
      end

      v1_q  <= cmd_i.issue_b || cmd_i.issue_f;
      fb1_q <= cmd_i.issue_f;
      v2_q  <= v1_q;
      fb2_q <= fb1_q;

      if (cmd_i.push) begin
        acc_q <= '0;
      end else if (v2_q) begin
        acc_q <= fb2_q ? acc_q - AW'(prod_q) : acc_q + AW'(prod_q);
      end

      if (cmd_i.accum) begin
        hw_q[ch_idx] <= hw_inc;
        sum_q        <= sum_d;
        clip_q       <= clip_q || wclip_q || sum_ovf;
      end else if (cmd_i.clr_sum || cmd_i.emit) begin
        sum_q  <= '0;
        clip_q <= 1'b0;
      end

      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // ---- status ----
  always_comb begin
    sts_o            = '0;
    sts_o.action     = item_q.action;
    sts_o.ch_ok      = int'(item_q.channel) < NUM_CHANNELS;
    sts_o.tap_ok_b   = int'(item_q.tap) < NUM_B_TAPS;
    sts_o.tap_ok_f   = int'(item_q.tap) < NUM_F_TAPS;
    sts_o.step_last  = item_q.step_last;
    sts_o.sweep_done = sweep_q == SWP_W'(SWEEP_LEN - 1);
    sts_o.tap_last_b = tap_q == TC_W'(NUM_B_TAPS - 1);
    sts_o.tap_last_f = tap_q == TC_W'(FB_TAPS);
    sts_o.pipe_idle  = !v1_q && !v2_q;
    sts_o.out_free   = !out_valid_q || out_ready_i;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

`default_nettype wire

@@ hw/rtl/multichannel_iir_filter_bank_sum_core.sv @@
// Top level of the multichannel IIR filter bank sum core.
// Depends on mifb_pkg, mifb_stream_if, mifb_ctrl, mifb_dp (and mifb_ram).
`default_nettype none

// Multi-input, single-output estimator. Every channel runs its own rational
// filter w = B/F over its sample history (Q8.15 samples, Q9.14 coefficients,
// Q16.15 outputs); the channel outputs of one time step are summed into a
// 40-bit saturating running sum, and the sample marked step_last emits that
// sum clipped to 32 bits plus a flag telling whether any clip happened in the
// step. Transactions on sample_i carry an action: sample, load numerator tap,
// load denominator tap (tap 0 is stored but never used, the leading term is
// an implied 1), or clear histories. Samples and loads for a channel at or
// above NUM_CHANNELS are dropped; loads beyond the tap count are dropped.
// Timing: one transaction is processed at a time and sample_i.ready is high
// only when the core is idle. A sample's processing time is set by the single
// shared multiply-accumulate, which takes one tap per cycle out of the
// coefficient and history memories, plus the read/multiply/accumulate pipeline
// drain and rounding. A clear-histories transaction sweeps the history
// memories one entry per cycle. After reset the same sweep also zeros the
// coefficient memories; sample_i.ready stays low until it is done. A finished
// result waits in an output register on result_o, and the core keeps taking
// transactions meanwhile; it only holds at the end of the next emitting sample
// if the previous result has still not been taken.
module multichannel_iir_filter_bank_sum_core #(
  parameter int NUM_CHANNELS = 16,
  parameter int NUM_B_TAPS   = 16,
  parameter int NUM_F_TAPS   = 8
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  mifb_stream_if.sink    sample_i,
  mifb_stream_if.source  result_o
);

  mifb_pkg::dp_cmd_t   cmd;
  mifb_pkg::dp_sts_t   sts;
  mifb_pkg::in_item_t  in_item;
  mifb_pkg::out_item_t out_item;
  logic                in_ready;
  logic                out_valid;

  assign in_item        = sample_i.data;
  assign sample_i.ready = in_ready;

  // Sequencer: decode, tap walk, drain, round, accumulate, emit
  mifb_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .in_valid_i (sample_i.valid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Memories, ring pointers and the shared MAC
  mifb_dp #(
    .NUM_CHANNELS (NUM_CHANNELS),
    .NUM_B_TAPS   (NUM_B_TAPS),
    .NUM_F_TAPS   (NUM_F_TAPS)
  ) u_dp (
    .clk_i,
    .rst_ni,
    .cmd_i       (cmd),
    .sts_o       (sts),
    .item_i      (in_item),
    .out_ready_i (result_o.ready),
    .out_valid_o (out_valid),
    .out_item_o  (out_item)
  );

  assign result_o.valid = out_valid;
  assign result_o.data  = out_item;

endmodule

`default_nettype wire
